FILE: hw/rtl/bitmap_allocator_find_first_free_core_defines.svh
// assertion macros used by the bitmap allocator controller
`ifndef BITMAP_ALLOCATOR_FIND_FIRST_FREE_CORE_DEFINES_SVH
`define BITMAP_ALLOCATOR_FIND_FIRST_FREE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define BMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/bmf_pkg.sv
// types, constants and helpers for the bitmap allocator
`default_nettype none

package bmf_pkg;

    localparam int NUM_WORDS_DEF = 1024;
    localparam int WORD_W        = 32;
    localparam int CFG_W         = 11;
    localparam int IDX_W         = 10;
    localparam int BIT_W         = 5;

    localparam logic [CFG_W-1:0]  WIU_RESET = 11'd1024;
    localparam logic [WORD_W-1:0] FULL_WORD = 32'hffff_ffff;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TEST  = 2'd2,
        OP_FIND  = 2'd3
    } op_t;

    typedef struct packed {
        op_t              opcode;
        logic [IDX_W-1:0] word_index;
        logic [BIT_W-1:0] bit_offset;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] free_word;
        logic [BIT_W-1:0] free_bit;
        logic             bit_value;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR      = 3'd0,
        ST_IDLE       = 3'd1,
        ST_READ       = 3'd2,
        ST_MODIFY     = 3'd3,
        ST_FIND_READ  = 3'd4,
        ST_FIND_CHECK = 3'd5
    } state_t;

    typedef enum logic [1:0] {
        RES_ACCESS = 2'd0,
        RES_FIND   = 2'd1,
        RES_NONE   = 2'd2
    } res_sel_t;

    // controller to datapath
    typedef struct packed {
        logic     latch_item;
        logic     scan_clr;
        logic     scan_inc;
        logic     addr_scan;
        logic     ram_rd;
        logic     ram_wr;
        logic     wr_zero;
        logic     load_result;
        res_sel_t res_sel;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  in_opcode;
        op_t  opcode;
        logic in_range;
        logic clear_last;
        logic scan_empty;
        logic scan_last;
        logic word_full;
    } status_t;

    // offset of the lowest clear bit; isolate it as a one-hot, then encode
    function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] onehot;
        logic [BIT_W-1:0]  idx;
        onehot = ~word & (word + WORD_W'(1));
        idx    = '0;
        for (int k = 0; k < BIT_W; k++) begin
            for (int b = 0; b < WORD_W; b++) begin
                if (((b >> k) & 1) == 1) begin
                    idx[k] = idx[k] | onehot[b];
                end
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bmf_ram.sv
// generic single write port ram with registered read
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bmf_ctrl.sv
// controller state machine for the bitmap allocator
`default_nettype none
`include "bitmap_allocator_find_first_free_core_defines.svh"

module bmf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    input  wire bmf_pkg::status_t status,
    output bmf_pkg::cmd_t         cmd
);

    bmf_pkg::state_t state_reg;
    bmf_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_free;
    logic            is_write_op;
    logic            access_start;

    assign out_free    = !out_valid_reg || !out_stall;
    assign is_write_op = (status.opcode == bmf_pkg::OP_SET) ||
                         (status.opcode == bmf_pkg::OP_CLEAR);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmf_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmf_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = bmf_pkg::ST_IDLE;
                end
            end
            bmf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.in_opcode == bmf_pkg::OP_FIND)
                    begin
                        state_next = bmf_pkg::ST_FIND_READ;
                    end
                    else
                    begin
                        state_next = bmf_pkg::ST_READ;
                    end
                end
            end
            bmf_pkg::ST_READ:
            begin
                state_next = bmf_pkg::ST_MODIFY;
            end
            bmf_pkg::ST_MODIFY:
            begin
                if (out_free)
                begin
                    state_next = bmf_pkg::ST_IDLE;
                end
            end
            bmf_pkg::ST_FIND_READ:
            begin
                if (!status.scan_empty)
                begin
                    state_next = bmf_pkg::ST_FIND_CHECK;
                end
                else if (out_free)
                begin
                    state_next = bmf_pkg::ST_IDLE;
                end
            end
            bmf_pkg::ST_FIND_CHECK:
            begin
                if (!status.word_full || status.scan_last)
                begin
                    if (out_free)
                    begin
                        state_next = bmf_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = bmf_pkg::ST_FIND_READ;
                end
            end
            default:
            begin
                state_next = bmf_pkg::ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != bmf_pkg::ST_IDLE);
        case (state_reg)
            bmf_pkg::ST_CLEAR:
            begin
                cmd.ram_wr    = 1'b1;
                cmd.wr_zero   = 1'b1;
                cmd.addr_scan = 1'b1;
                cmd.scan_inc  = 1'b1;
            end
            bmf_pkg::ST_IDLE:
            begin
                cmd.latch_item = in_valid;
                cmd.scan_clr   = in_valid;
            end
            bmf_pkg::ST_READ:
            begin
                cmd.ram_rd = 1'b1;
            end
            bmf_pkg::ST_MODIFY:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_sel     = bmf_pkg::RES_ACCESS;
                    cmd.ram_wr      = is_write_op && status.in_range;
                end
            end
            bmf_pkg::ST_FIND_READ:
            begin
                if (status.scan_empty)
                begin
                    cmd.load_result = out_free;
                    cmd.res_sel     = bmf_pkg::RES_NONE;
                end
                else
                begin
                    cmd.ram_rd    = 1'b1;
                    cmd.addr_scan = 1'b1;
                end
            end
            bmf_pkg::ST_FIND_CHECK:
            begin
                if (!status.word_full)
                begin
                    cmd.load_result = out_free;
                    cmd.res_sel     = bmf_pkg::RES_FIND;
                end
                else if (status.scan_last)
                begin
                    cmd.load_result = out_free;
                    cmd.res_sel     = bmf_pkg::RES_NONE;
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    // accepted set, clear or test word
    assign access_start = in_valid && !in_stall && (status.in_opcode != bmf_pkg::OP_FIND);

    // a new result never overwrites a word still waiting to be taken
    `BMF_ASSERT_NOW(a_no_overwrite, cmd.load_result, !out_valid_reg || !out_stall, "result overwritten")
    // memory is never written while waiting for a request
    `BMF_ASSERT_NOW(a_no_idle_write, state_reg == bmf_pkg::ST_IDLE, !cmd.ram_wr, "write in idle")
    // an accepted set, clear or test goes straight to its read
    `BMF_ASSERT_NEXT(a_access_path, access_start, state_reg == bmf_pkg::ST_READ, "access did not start")

endmodule

`default_nettype wire

FILE: hw/rtl/bmf_dp.sv
// datapath of the bitmap allocator: store, scan counter, result word
`default_nettype none

module bmf_dp #(
    parameter int NUM_WORDS = bmf_pkg::NUM_WORDS_DEF,
    localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
    localparam int LW = (AW + 1 > bmf_pkg::CFG_W) ? AW + 1 : bmf_pkg::CFG_W
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bmf_pkg::req_t              in_data,
    input  wire logic                       cfg_we,
    input  wire logic [bmf_pkg::CFG_W-1:0]  cfg_data,
    input  wire bmf_pkg::cmd_t              cmd,
    output bmf_pkg::status_t                status,
    output bmf_pkg::rsp_t                   out_data
);

    bmf_pkg::req_t                item_reg;
    logic [bmf_pkg::CFG_W-1:0]    words_in_use_reg;
    logic [AW-1:0]                scan_reg;
    bmf_pkg::rsp_t                out_data_reg;
    bmf_pkg::rsp_t                result;
    logic [LW-1:0]                limit;
    logic [AW-1:0]                addr;
    logic [bmf_pkg::WORD_W-1:0]   rd_data;
    logic [bmf_pkg::WORD_W-1:0]   wr_data;
    logic [bmf_pkg::WORD_W-1:0]   mask;
    logic                         in_range;

    // request word captured at accept
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_data;
        end
    end

    // search length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_in_use_reg <= bmf_pkg::WIU_RESET;
        end
        else if (cfg_we)
        begin
            words_in_use_reg <= cfg_data;
        end
    end

    // word counter for the clearing pass and the search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_clr)
        begin
            scan_reg <= '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_reg <= scan_reg + AW'(1);
        end
    end

    // search limit is the smaller of the register and the store size
    assign limit = (LW'(words_in_use_reg) < LW'(NUM_WORDS)) ?
                   LW'(words_in_use_reg) : LW'(NUM_WORDS);

    assign in_range = LW'(item_reg.word_index) < LW'(NUM_WORDS);
    assign addr     = cmd.addr_scan ? scan_reg : AW'(item_reg.word_index);
    assign mask     = bmf_pkg::WORD_W'(1) << item_reg.bit_offset;

    // modified word for set and clear, or zero during the clearing pass
    always_comb
    begin
        if (cmd.wr_zero)
        begin
            wr_data = '0;
        end
        else if (item_reg.opcode == bmf_pkg::OP_SET)
        begin
            wr_data = rd_data | mask;
        end
        else
        begin
            wr_data = rd_data & ~mask;
        end
    end

    bmf_ram #(
        .WIDTH (bmf_pkg::WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (addr),
        .wr_data (wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // status back to the controller
    always_comb
    begin
        status.in_opcode  = in_data.opcode;
        status.opcode     = item_reg.opcode;
        status.in_range   = in_range;
        status.clear_last = (scan_reg == AW'(NUM_WORDS - 1));
        status.scan_empty = (limit == '0);
        status.scan_last  = ((LW'(scan_reg) + LW'(1)) == limit);
        status.word_full  = (rd_data == bmf_pkg::FULL_WORD);
    end

    // result word select
    always_comb
    begin
        result = '0;
        case (cmd.res_sel)
            bmf_pkg::RES_ACCESS:
            begin
                result.found     = 1'b1;
                result.bit_value = rd_data[item_reg.bit_offset] && in_range &&
                                   (item_reg.opcode == bmf_pkg::OP_TEST);
            end
            bmf_pkg::RES_FIND:
            begin
                result.found     = 1'b1;
                result.free_word = bmf_pkg::IDX_W'(scan_reg);
                result.free_bit  = bmf_pkg::first_zero(rd_data);
            end
            bmf_pkg::RES_NONE:
            begin
                result = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_data_reg <= result;
        end
    end

    assign out_data = out_data_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/bitmap_allocator_find_first_free_core.sv
// bitmap allocator top level: set, clear, test and find-first-free on a word store
// set, clear, test: READ reads the store word, MODIFY loads the result and writes back
//   a set or clear; find: a store read, then a check, for each word until one not full
//   or the limit is reached; requests are taken only in IDLE, once the result is loaded
// reset: a clearing pass zeroes the store, one word a cycle, with in_stall high;
//   words_in_use resets to 1024; configuration writes are taken at any time
`default_nettype none

module bitmap_allocator_find_first_free_core #(
    parameter int NUM_WORDS = bmf_pkg::NUM_WORDS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire bmf_pkg::req_t             in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output bmf_pkg::rsp_t                  out_data,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bmf_pkg::CFG_W-1:0] cfg_data
);

    bmf_pkg::cmd_t    cmd;
    bmf_pkg::status_t status;

    // config register always writable
    assign cfg_ready = 1'b1;

    bmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bmf_dp #(
        .NUM_WORDS (NUM_WORDS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
